### src/ogrc_pkg.sv
// Shared constants, types and command/status structs for the occupancy grid ray clear block.
package ogrc_pkg;

  // Grid geometry.
  localparam int GRID_COLS = 256;
  localparam int GRID_ROWS = 256;
  localparam int CELLS     = GRID_COLS * GRID_ROWS;
  localparam int ADDR_W    = $clog2(CELLS);

  // Field widths.
  localparam int COORD_W = 8;
  localparam int KIND_W  = 2;
  localparam int VAL_W   = 2;
  localparam int REG_W   = 9;
  localparam int IDX_W   = 2;

  // Width that holds a register value as well as either grid dimension.
  localparam int DIM_MAX = (GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS;
  localparam int CNT_W   = $clog2((DIM_MAX > 511) ? (DIM_MAX + 1) : 512);

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TRACE = 2'd2;

  // Cell codes.
  localparam logic [VAL_W-1:0] CELL_UNKNOWN  = 2'd0;
  localparam logic [VAL_W-1:0] CELL_FREE     = 2'd1;
  localparam logic [VAL_W-1:0] CELL_OBSTACLE = 2'd2;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_STOP = 2'd0;
  localparam logic [IDX_W-1:0] REG_COLS = 2'd1;
  localparam logic [IDX_W-1:0] REG_ROWS = 2'd2;

  // Memory address sources.
  localparam logic [1:0] ASEL_CLEAR = 2'd0;
  localparam logic [1:0] ASEL_ITEM  = 2'd1;
  localparam logic [1:0] ASEL_RAY   = 2'd2;

  typedef struct packed {
    logic             stop_en;
    logic [CNT_W-1:0] cols;
    logic [CNT_W-1:0] rows;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       init;
    logic       col_setup;
    logic       advance;
    logic       mem_re;
    logic       mem_we;
    logic [1:0] asel;
    logic       clr_step;
    logic       capture_read;
    logic       set_hit;
    logic       set_bad;
  } cmd_t;

  typedef struct packed {
    logic              clear_last;
    logic [KIND_W-1:0] kind;
    logic              start_ok;
    logic              end_ok;
    logic              stop_en;
    logic              span_zero;
    logic              cell_last;
    logic              col_last;
    logic              obstacle;
  } stat_t;

endpackage

### src/ogrc_ctrl.sv
// Controller state machine that sequences clearing, cell access and ray walking.
module ogrc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  ogrc_pkg::stat_t stat,
  input  logic           in_valid,
  input  logic           out_free,
  output logic           in_ready,
  output logic           out_load,
  output ogrc_pkg::cmd_t cmd
);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_DECODE = 4'd2;
  localparam logic [3:0] ST_RDW    = 4'd3;
  localparam logic [3:0] ST_COL    = 4'd4;
  localparam logic [3:0] ST_CELL   = 4'd5;
  localparam logic [3:0] ST_CHK    = 4'd6;
  localparam logic [3:0] ST_FINISH = 4'd7;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [3:0] after_cell;

  // Where the walk goes after the current cell is marked.
  always_comb begin
    if (!stat.cell_last) begin
      after_cell = ST_CELL;
    end else if (stat.col_last) begin
      after_cell = ST_FINISH;
    end else begin
      after_cell = ST_COL;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        cmd.mem_we   = 1'b1;
        cmd.asel     = ogrc_pkg::ASEL_CLEAR;
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_FINISH;
        cmd.asel   = ogrc_pkg::ASEL_ITEM;
        unique case (stat.kind)
          ogrc_pkg::KIND_WRITE: begin
            if (!stat.start_ok) begin
              cmd.set_bad = 1'b1;
            end else begin
              cmd.mem_we = 1'b1;
            end
          end
          ogrc_pkg::KIND_READ: begin
            if (!stat.start_ok) begin
              cmd.set_bad = 1'b1;
            end else begin
              cmd.mem_re = 1'b1;
              state_next = ST_RDW;
            end
          end
          ogrc_pkg::KIND_TRACE: begin
            if (!(stat.start_ok && stat.end_ok)) begin
              cmd.set_bad = 1'b1;
            end else begin
              cmd.init = 1'b1;
              if (!stat.span_zero) begin
                state_next = ST_COL;
              end
            end
          end
          default: begin
            state_next = ST_FINISH;
          end
        endcase
      end
      ST_RDW: begin
        cmd.capture_read = 1'b1;
        state_next       = ST_FINISH;
      end
      ST_COL: begin
        cmd.col_setup = 1'b1;
        state_next    = ST_CELL;
      end
      ST_CELL: begin
        cmd.asel = ogrc_pkg::ASEL_RAY;
        if (stat.stop_en) begin
          cmd.mem_re = 1'b1;
          state_next = ST_CHK;
        end else begin
          cmd.mem_we  = 1'b1;
          cmd.advance = 1'b1;
          state_next  = after_cell;
        end
      end
      ST_CHK: begin
        cmd.asel = ogrc_pkg::ASEL_RAY;
        if (stat.obstacle) begin
          cmd.set_hit = 1'b1;
          state_next  = ST_FINISH;
        end else begin
          cmd.mem_we  = 1'b1;
          cmd.advance = 1'b1;
          state_next  = after_cell;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

### src/ogrc_dp.sv
// Datapath: grid memory, item registers, ray stepping arithmetic and result fields.
module ogrc_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  ogrc_pkg::cmd_t                   cmd,
  input  ogrc_pkg::cfg_t                   cfg,
  input  logic [ogrc_pkg::KIND_W-1:0]      in_kind,
  input  logic [ogrc_pkg::COORD_W-1:0]     in_sx,
  input  logic [ogrc_pkg::COORD_W-1:0]     in_sy,
  input  logic [ogrc_pkg::COORD_W-1:0]     in_ex,
  input  logic [ogrc_pkg::COORD_W-1:0]     in_ey,
  input  logic [ogrc_pkg::VAL_W-1:0]       in_wv,
  output ogrc_pkg::stat_t                  stat,
  output logic [ogrc_pkg::VAL_W-1:0]       res_read,
  output logic                             res_hit,
  output logic                             res_bad
);

  localparam int CW = ogrc_pkg::COORD_W;
  localparam int AW = ogrc_pkg::ADDR_W;

  // Grid storage.
  logic [ogrc_pkg::VAL_W-1:0] mem [ogrc_pkg::CELLS];
  logic [ogrc_pkg::VAL_W-1:0] rdata;
  logic [AW-1:0]              addr;
  logic [ogrc_pkg::VAL_W-1:0] wdata;
  logic [AW-1:0]              clr_cnt;

  // Latched item.
  logic [ogrc_pkg::KIND_W-1:0] kind;
  logic [CW-1:0]               sx, sy, ex, ey;
  logic [ogrc_pkg::VAL_W-1:0]  wv;

  // Ray walk registers.
  logic          swapped, step_neg, dm_neg;
  logic [CW-1:0] span, adm, m0;
  logic [CW-1:0] a, k, q, r, mk, mcur, mhi;

  // Setup values derived from the latched item.
  logic [CW-1:0] adx, ady;
  logic          dx_neg, dy_neg, sw_c;

  always_comb begin
    dx_neg = ex < sx;
    dy_neg = ey < sy;
    adx    = dx_neg ? (sx - ex) : (ex - sx);
    ady    = dy_neg ? (sy - ey) : (ey - sy);
    sw_c   = ady > adx;
  end

  // Minor coordinate one step further along the major axis.
  logic [CW:0]   r_sum;
  logic          wrap;
  logic [CW-1:0] r1, q1, m_next, lo, hi;

  always_comb begin
    r_sum  = {1'b0, r} + {1'b0, adm};
    wrap   = r_sum >= {1'b0, span};
    r1     = wrap ? CW'(r_sum - {1'b0, span}) : r_sum[CW-1:0];
    q1     = q + CW'(wrap);
    m_next = dm_neg ? (m0 - q1 - CW'(r1 != '0)) : (m0 + q1);
    if (k == '0) begin
      lo = mk;
      hi = mk;
    end else if (m_next < mk) begin
      lo = m_next;
      hi = mk;
    end else begin
      lo = mk;
      hi = m_next;
    end
  end

  // Memory address and write data.
  logic [CW-1:0] ray_col, ray_row;

  always_comb begin
    ray_col = swapped ? mcur : a;
    ray_row = swapped ? a : mcur;
    unique case (cmd.asel)
      ogrc_pkg::ASEL_CLEAR: begin
        addr  = clr_cnt;
        wdata = ogrc_pkg::CELL_UNKNOWN;
      end
      ogrc_pkg::ASEL_ITEM: begin
        addr  = AW'(int'(sy) * ogrc_pkg::GRID_COLS + int'(sx));
        wdata = wv;
      end
      default: begin
        addr  = AW'(int'(ray_row) * ogrc_pkg::GRID_COLS + int'(ray_col));
        wdata = ogrc_pkg::CELL_FREE;
      end
    endcase
  end

  // Single-port grid memory with registered read.
  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[addr] <= wdata;
    end
    if (cmd.mem_re) begin
      rdata <= mem[addr];
    end
  end

  // Clearing sweep counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= in_kind;
      sx   <= in_sx;
      sy   <= in_sy;
      ex   <= in_ex;
      ey   <= in_ey;
      wv   <= in_wv;
    end
  end

  // Ray walk: setup, per-column minor range, per-cell stepping.
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      swapped  <= sw_c;
      step_neg <= sw_c ? dy_neg : dx_neg;
      dm_neg   <= sw_c ? dx_neg : dy_neg;
      span     <= sw_c ? ady : adx;
      adm      <= sw_c ? adx : ady;
      m0       <= sw_c ? sx : sy;
      a        <= sw_c ? sy : sx;
      mk       <= sw_c ? sx : sy;
      k        <= '0;
      q        <= '0;
      r        <= '0;
    end else if (cmd.col_setup) begin
      mcur <= lo;
      mhi  <= hi;
      mk   <= m_next;
      q    <= q1;
      r    <= r1;
    end else if (cmd.advance) begin
      if (mcur == mhi) begin
        a <= step_neg ? (a - CW'(1)) : (a + CW'(1));
        k <= k + CW'(1);
      end else begin
        mcur <= mcur + CW'(1);
      end
    end
  end

  // Result fields, cleared for each new item.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_read <= ogrc_pkg::CELL_UNKNOWN;
      res_hit  <= 1'b0;
      res_bad  <= 1'b0;
    end else begin
      if (cmd.capture_read) begin
        res_read <= rdata;
      end
      if (cmd.set_hit) begin
        res_hit <= 1'b1;
      end
      if (cmd.set_bad) begin
        res_bad <= 1'b1;
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.clear_last = clr_cnt == AW'(ogrc_pkg::CELLS - 1);
    stat.kind       = kind;
    stat.start_ok   = (ogrc_pkg::CNT_W'(sx) < cfg.cols) && (ogrc_pkg::CNT_W'(sy) < cfg.rows);
    stat.end_ok     = (ogrc_pkg::CNT_W'(ex) < cfg.cols) && (ogrc_pkg::CNT_W'(ey) < cfg.rows);
    stat.stop_en    = cfg.stop_en;
    stat.span_zero  = (adx == '0) && (ady == '0);
    stat.cell_last  = mcur == mhi;
    stat.col_last   = k == (span - CW'(1));
    stat.obstacle   = rdata == ogrc_pkg::CELL_OBSTACLE;
  end

endmodule

### src/occupancy_grid_ray_clear.sv
// Top level: configuration registers, result register and controller/datapath pair.
//
//   channel   direction  handshake               payload
//   s_axis    in         tvalid/tready           tuser kind, tdata ray or cell request
//   m_axis    out        tvalid/tready           tdata result
//   cfg       in         cfg_we (always taken)   cfg_index, cfg_data
//
// A write request passes through the decode state before its result is offered; a read
// also passes through the read-wait state. A trace sets up each column and then marks
// its cells; with stop on obstacle each cell is first read and then written, in separate
// states, through the single grid memory port. After reset a clearing pass writes all
// 65536 cells, one per cycle, and no request is taken until it ends; configuration writes
// are taken throughout. A result waiting on m_axis stalls only the finish of the next
// request, which is accepted meanwhile.
module occupancy_grid_ray_clear (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // fields from bit 0: start_x, start_y, end_x, end_y, write_value, zero fill
  input  logic [39:0]                    s_axis_tdata,
  // fields from bit 0: kind
  input  logic [ogrc_pkg::KIND_W-1:0]    s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // fields from bit 0: read_value, hit_obstacle, bad_coords, zero fill
  output logic [7:0]                     m_axis_tdata,
  input  logic                           cfg_we,
  input  logic [ogrc_pkg::IDX_W-1:0]     cfg_index,
  input  logic [ogrc_pkg::REG_W-1:0]     cfg_data
);

  localparam int CNW = ogrc_pkg::CNT_W;

  logic                        stop_reg;
  logic [ogrc_pkg::REG_W-1:0]  cols_reg, rows_reg;
  ogrc_pkg::cfg_t              cfg;
  ogrc_pkg::cmd_t              cmd;
  ogrc_pkg::stat_t             stat;
  logic                        out_load, out_free;
  logic [ogrc_pkg::VAL_W-1:0]  res_read;
  logic                        res_hit, res_bad;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_reg <= 1'b1;
      cols_reg <= 9'd256;
      rows_reg <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ogrc_pkg::REG_STOP: stop_reg <= cfg_data[0];
        ogrc_pkg::REG_COLS: cols_reg <= cfg_data;
        ogrc_pkg::REG_ROWS: rows_reg <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Dimensions in use are clamped to the grid.
  always_comb begin
    cfg.stop_en = stop_reg;
    cfg.cols    = (CNW'(cols_reg) > CNW'(ogrc_pkg::GRID_COLS)) ?
                  CNW'(ogrc_pkg::GRID_COLS) : CNW'(cols_reg);
    cfg.rows    = (CNW'(rows_reg) > CNW'(ogrc_pkg::GRID_ROWS)) ?
                  CNW'(ogrc_pkg::GRID_ROWS) : CNW'(rows_reg);
  end

  ogrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .in_valid (s_axis_tvalid),
    .out_free (out_free),
    .in_ready (s_axis_tready),
    .out_load (out_load),
    .cmd      (cmd)
  );

  ogrc_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_kind  (s_axis_tuser),
    .in_sx    (s_axis_tdata[7:0]),
    .in_sy    (s_axis_tdata[15:8]),
    .in_ex    (s_axis_tdata[23:16]),
    .in_ey    (s_axis_tdata[31:24]),
    .in_wv    (s_axis_tdata[33:32]),
    .stat     (stat),
    .res_read (res_read),
    .res_hit  (res_hit),
    .res_bad  (res_bad)
  );

  // Result register; it can be refilled in the cycle it is taken.
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {4'b0000, res_bad, res_hit, res_read};
    end
  end

endmodule

### sim/tb_top.sv
// Self-checking testbench for the occupancy grid ray clear block.
module tb_top;
  import ogrc_pkg::*;

  // Codes that the package leaves unnamed.
  localparam logic [KIND_W-1:0] KIND_NONE      = 2'd3;
  localparam logic [VAL_W-1:0]  CELL_FOOTPRINT = 2'd3;

  localparam int  HOLD_CYCLES = 3000;
  localparam int  HOT_SPAN    = 16;
  localparam bit  TYPED       = 1'b1;
  localparam bit  PREDICTED   = 1'b0;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [VAL_W-1:0]   write_value;
  } cell_request_t;

  // Result layout on m_axis_tdata, MSB first.
  typedef struct packed {
    logic [3:0]       fill;
    logic             bad_coords;
    logic             hit_obstacle;
    logic [VAL_W-1:0] read_value;
  } cell_result_t;

  typedef struct {
    cell_result_t res;
    int           item_no;
  } awaited_t;

  // One row of the directed table: a register write or a request.
  typedef struct {
    bit               is_reg;
    logic [IDX_W-1:0] reg_index;
    logic [REG_W-1:0] reg_value;
    cell_request_t    req;
    bit               typed;
    cell_result_t     res;
  } plan_row_t;

  localparam cell_result_t RES_CLEAN = '0;
  localparam cell_result_t RES_HIT   = '{fill: 4'd0, bad_coords: 1'b0, hit_obstacle: 1'b1,
                                         read_value: CELL_UNKNOWN};
  localparam cell_result_t RES_BAD   = '{fill: 4'd0, bad_coords: 1'b1, hit_obstacle: 1'b0,
                                         read_value: CELL_UNKNOWN};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  // start_x, start_y, end_x, end_y, write_value, zero fill (from bit 0)
  logic [39:0]        s_axis_tdata = '0;
  // kind
  logic [KIND_W-1:0]  s_axis_tuser = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // read_value, hit_obstacle, bad_coords, zero fill (from bit 0)
  logic [7:0]         m_axis_tdata;
  logic               cfg_we = 1'b0;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [REG_W-1:0]   cfg_data = '0;

  occupancy_grid_ray_clear u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // Grid and register copies kept by the predictor.
  logic [VAL_W-1:0] grid_model [GRID_COLS*GRID_ROWS];
  logic             model_stop = 1'b1;
  logic [REG_W-1:0] model_cols = 9'd256;
  logic [REG_W-1:0] model_rows = 9'd256;

  awaited_t     awaited_results[$];
  plan_row_t    plan[$];
  cell_result_t seen;
  awaited_t     head;

  int send_idle_pct = 7;
  int recv_idle_pct = 68;
  int hold_left = 0;
  int items_sent = 0;
  int traces_sent = 0;
  int results_seen = 0;
  int obstacle_stops = 0;
  int bad_flags = 0;
  int mismatches = 0;

  function automatic int dim_in_use(logic [REG_W-1:0] reg_val, int dim);
    return (int'(reg_val) > dim) ? dim : int'(reg_val);
  endfunction

  // Exact floor of the minor coordinate k steps along the major axis.
  function automatic int ray_minor(int m0, int dm, int span, int k);
    if (dm >= 0) return m0 + (k * dm) / span;
    return m0 - (k * (-dm) + span - 1) / span;
  endfunction

  // Frees the cells the ray crosses; returns 1 when it stops at an obstacle.
  function automatic bit clear_along_ray(int sx, int sy, int ex, int ey);
    int dx, dy, adx, ady, a0, m0, da, dm, span, dir, a, lo, hi, nx, col, row;
    bit swapped;
    dx = ex - sx;
    dy = ey - sy;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    swapped = ady > adx;
    a0 = swapped ? sy : sx;
    m0 = swapped ? sx : sy;
    da = swapped ? dy : dx;
    dm = swapped ? dx : dy;
    span = (da < 0) ? -da : da;
    dir = (da < 0) ? -1 : 1;
    for (int k = 0; k < span; k++) begin
      a = a0 + k * dir;
      lo = ray_minor(m0, dm, span, k);
      hi = lo;
      // Later columns cover the whole step to the next column's minor value.
      if (k != 0) begin
        nx = ray_minor(m0, dm, span, k + 1);
        if (nx < lo) lo = nx;
        else hi = nx;
      end
      for (int m = lo; m <= hi; m++) begin
        col = swapped ? m : a;
        row = swapped ? a : m;
        if (model_stop && grid_model[row * GRID_COLS + col] == CELL_OBSTACLE) return 1'b1;
        grid_model[row * GRID_COLS + col] = CELL_FREE;
      end
    end
    return 1'b0;
  endfunction

  // Applies one request to the grid copy and returns the result it causes.
  function automatic cell_result_t apply_request(cell_request_t r);
    cell_result_t res;
    int cols, rows, idx;
    bit start_ok, end_ok;
    res = RES_CLEAN;
    cols = dim_in_use(model_cols, GRID_COLS);
    rows = dim_in_use(model_rows, GRID_ROWS);
    start_ok = (int'(r.start_x) < cols) && (int'(r.start_y) < rows);
    end_ok = (int'(r.end_x) < cols) && (int'(r.end_y) < rows);
    idx = int'(r.start_y) * GRID_COLS + int'(r.start_x);
    case (r.kind)
      KIND_WRITE, KIND_READ: begin
        if (!start_ok) res.bad_coords = 1'b1;
        else if (r.kind == KIND_WRITE) grid_model[idx] = r.write_value;
        else res.read_value = grid_model[idx];
      end
      KIND_TRACE: begin
        if (!start_ok || !end_ok) res.bad_coords = 1'b1;
        else res.hit_obstacle = clear_along_ray(int'(r.start_x), int'(r.start_y),
                                                int'(r.end_x), int'(r.end_y));
      end
      default: ;
    endcase
    return res;
  endfunction

  // Mostly inside a small hot corner so that writes, reads and rays overlap.
  function automatic logic [COORD_W-1:0] random_coord(int limit);
    int pick;
    pick = $urandom_range(9);
    if (limit == 0 || pick == 0) return COORD_W'($urandom_range(255));
    if (pick < 7) return COORD_W'($urandom_range(((limit < HOT_SPAN) ? limit : HOT_SPAN) - 1));
    return COORD_W'($urandom_range(limit - 1));
  endfunction

  function automatic cell_request_t random_request();
    cell_request_t r;
    int pick, cols, rows;
    cols = dim_in_use(model_cols, GRID_COLS);
    rows = dim_in_use(model_rows, GRID_ROWS);
    pick = $urandom_range(99);
    if (pick < 22) r.kind = KIND_WRITE;
    else if (pick < 44) r.kind = KIND_READ;
    else if (pick < 96) r.kind = KIND_TRACE;
    else r.kind = KIND_NONE;
    r.start_x = random_coord(cols);
    r.start_y = random_coord(rows);
    r.end_x = random_coord(cols);
    r.end_y = random_coord(rows);
    r.write_value = ($urandom_range(99) < 40) ? CELL_OBSTACLE : VAL_W'($urandom_range(3));
    return r;
  endfunction

  // Offers one request, waits for it to be taken, then records its result.
  task automatic send_request(cell_request_t r, bit typed, cell_result_t typed_res);
    awaited_t entry;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, r.write_value, r.end_y, r.end_x, r.start_y, r.start_x};
    s_axis_tuser <= r.kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    entry.res = apply_request(r);
    if (typed) entry.res = typed_res;
    entry.item_no = items_sent;
    awaited_results = {awaited_results, entry};
    items_sent++;
    if (r.kind == KIND_TRACE) traces_sent++;
  endtask

  // Stops offering and waits until every result is back.
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] index, logic [REG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    case (index)
      REG_STOP: model_stop = value[0];
      REG_COLS: model_cols = value;
      REG_ROWS: model_rows = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic plan_item(logic [KIND_W-1:0] kind, int sx, int sy, int ex, int ey,
                           logic [VAL_W-1:0] wv, bit typed, cell_result_t res);
    plan_row_t row;
    row.is_reg = 1'b0;
    row.reg_index = REG_STOP;
    row.reg_value = '0;
    row.req.kind = kind;
    row.req.start_x = COORD_W'(sx);
    row.req.start_y = COORD_W'(sy);
    row.req.end_x = COORD_W'(ex);
    row.req.end_y = COORD_W'(ey);
    row.req.write_value = wv;
    row.typed = typed;
    row.res = res;
    plan = {plan, row};
  endtask

  task automatic plan_reg(logic [IDX_W-1:0] index, logic [REG_W-1:0] value);
    plan_row_t row;
    row.is_reg = 1'b1;
    row.reg_index = index;
    row.reg_value = value;
    row.req = '{KIND_NONE, '0, '0, '0, '0, CELL_UNKNOWN};
    row.typed = 1'b0;
    row.res = RES_CLEAN;
    plan = {plan, row};
  endtask

  // One random phase under a new register setting.
  task automatic run_phase(bit stop, logic [REG_W-1:0] cols, logic [REG_W-1:0] rows,
                           int send_idle, int recv_idle, int count, int hold);
    settle();
    write_reg(REG_STOP, REG_W'(stop));
    write_reg(REG_COLS, cols);
    write_reg(REG_ROWS, rows);
    send_idle_pct = send_idle;
    recv_idle_pct = recv_idle;
    hold_left = hold;
    repeat (count) send_request(random_request(), PREDICTED, RES_CLEAN);
  endtask

  // Result side: random stalls, plus one long hold-off when asked.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare every returned result with the oldest outstanding expectation.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen = m_axis_tdata;
      results_seen++;
      if (seen.hit_obstacle) obstacle_stops++;
      if (seen.bad_coords) bad_flags++;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result %h with no request outstanding", m_axis_tdata);
      end else begin
        head = awaited_results.pop_front();
        if (seen.read_value !== head.res.read_value ||
            seen.hit_obstacle !== head.res.hit_obstacle ||
            seen.bad_coords !== head.res.bad_coords ||
            seen.fill !== head.res.fill) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Request %0d: expected value %0d hit %0b bad %0b fill %h, got %0d %0b %0b %h",
                     head.item_no, head.res.read_value, head.res.hit_obstacle,
                     head.res.bad_coords, head.res.fill, seen.read_value, seen.hit_obstacle,
                     seen.bad_coords, seen.fill);
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #80000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    foreach (grid_model[i]) grid_model[i] = CELL_UNKNOWN;

    // Directed table under the reset register values.
    plan_item(KIND_READ,    0,   0,   0,   0, CELL_UNKNOWN,   TYPED, RES_CLEAN);
    plan_item(KIND_READ,  255, 255,   0,   0, CELL_UNKNOWN,   TYPED, RES_CLEAN);
    plan_item(KIND_WRITE, 255, 255,   0,   0, CELL_FOOTPRINT, TYPED, RES_CLEAN);
    plan_item(KIND_READ,  255, 255,   0,   0, CELL_UNKNOWN,   TYPED, {6'd0, CELL_FOOTPRINT});
    plan_item(KIND_WRITE,   0,   0,   0,   0, CELL_OBSTACLE,  TYPED, RES_CLEAN);
    // A ray that starts on its end cell marks nothing.
    plan_item(KIND_TRACE,   0,   0,   0,   0, CELL_UNKNOWN,   TYPED, RES_CLEAN);
    plan_item(KIND_TRACE,   0,   0,  10,   0, CELL_UNKNOWN,   TYPED, RES_HIT);
    plan_item(KIND_READ,    0,   0,   0,   0, CELL_UNKNOWN,   TYPED, {6'd0, CELL_OBSTACLE});
    // Full diagonal, steep, backward and steep backward rays.
    plan_item(KIND_TRACE, 255, 255,   0,   0, CELL_UNKNOWN,   PREDICTED, RES_CLEAN);
    plan_item(KIND_READ,  255, 255,   0,   0, CELL_UNKNOWN,   PREDICTED, RES_CLEAN);
    plan_item(KIND_TRACE,   5,   0,   7, 200, CELL_UNKNOWN,   PREDICTED, RES_CLEAN);
    plan_item(KIND_TRACE, 200, 100,   3,  90, CELL_UNKNOWN,   PREDICTED, RES_CLEAN);
    plan_item(KIND_TRACE,  10, 200,  12,   3, CELL_UNKNOWN,   PREDICTED, RES_CLEAN);
    plan_item(KIND_WRITE, 100,  50,   0,   0, CELL_OBSTACLE,  TYPED, RES_CLEAN);
    plan_item(KIND_TRACE,  90,  50, 150,  50, CELL_UNKNOWN,   TYPED, RES_HIT);
    // The unused kind does nothing, whatever its fields.
    plan_item(KIND_NONE,  255, 255, 255, 255, CELL_FOOTPRINT, TYPED, RES_CLEAN);
    // Narrowed grid: out-of-range coordinates are flagged and ignored.
    plan_reg(REG_COLS, 9'd100);
    plan_item(KIND_WRITE, 100,   5,   0,   0, CELL_FREE,      TYPED, RES_BAD);
    plan_item(KIND_TRACE,   0,   0, 150,   3, CELL_UNKNOWN,   TYPED, RES_BAD);
    plan_item(KIND_READ,   99, 255,   0,   0, CELL_UNKNOWN,   PREDICTED, RES_CLEAN);
    plan_reg(REG_ROWS, 9'd0);
    plan_item(KIND_READ,    0,   0,   0,   0, CELL_UNKNOWN,   TYPED, RES_BAD);
    // Without the stop, an obstacle on the ray is freed like any cell.
    plan_reg(REG_STOP, 9'd0);
    plan_reg(REG_ROWS, 9'd256);
    plan_reg(REG_COLS, 9'd256);
    plan_item(KIND_TRACE,  90,  50, 150,  50, CELL_UNKNOWN,   TYPED, RES_CLEAN);
    plan_item(KIND_READ,  100,  50,   0,   0, CELL_UNKNOWN,   TYPED, {6'd0, CELL_FREE});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle();
        write_reg(plan[i].reg_index, plan[i].reg_value);
      end else begin
        send_request(plan[i].req, plan[i].typed, plan[i].res);
      end
    end

    // Random phases; the last one holds the result side off for a long stretch.
    run_phase(1'b0, 9'd511, 9'd200,  7, 68, 120, 0);
    run_phase(1'b1, 9'd1,   9'd256, 68,  7,  60, 0);
    run_phase(1'b1, 9'd40,  9'd1,   68,  7,  60, 0);
    run_phase(1'b1, 9'd256, 9'd256,  0,  0, 150, HOLD_CYCLES);
    settle();
    repeat (16) @(posedge clk);

    $display("Covered %0d requests (%0d ray traces) over several grid sizes and stop modes.",
             items_sent, traces_sent);
    $display("%0d results compared: %0d obstacle stops, %0d out-of-grid flags, %0d mismatches.",
             results_seen, obstacle_stops, bad_flags, mismatches);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
src/ogrc_pkg.sv
src/ogrc_ctrl.sv
src/ogrc_dp.sv
src/occupancy_grid_ray_clear.sv
sim/tb_top.sv
